[hdl/cpm_pkg.sv]
// Shared types and constants for the capture period meter.
package cpm_pkg;

    localparam int OP_W    = 2;
    localparam int CH_W    = 2;
    localparam int CNT_W   = 16;
    localparam int STAMP_W = 32;
    localparam int TMO_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_CAPTURE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_TOP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_US_PER_COUNT  = 2'd3;

    // result status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_CHAN = 1'b1;

    // output queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  channel;
        logic [CNT_W-1:0] capture_count;
    } in_item_t;

    typedef struct packed {
        logic               status;
        logic [STAMP_W-1:0] period_counts;
        logic [STAMP_W-1:0] period_us;
    } out_item_t;

    // per-channel record kept in the channel memory
    typedef struct packed {
        logic [STAMP_W-1:0] last_tick;
        logic [STAMP_W-1:0] acc_stamp;
        logic [STAMP_W-1:0] period;
    } chan_rec_t;

    // read request handed to the scaling stage
    typedef struct packed {
        logic               status;
        logic [STAMP_W-1:0] period;
    } scale_req_t;

endpackage

[hdl/cpm_chan_mem.sv]
// Per-channel state memory with valid bits and read-during-write bypass.
module cpm_chan_mem #(
    parameter int NUM_CHANNELS = 2,
    parameter int AW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [AW-1:0]     rd_addr,
    output cpm_pkg::chan_rec_t rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  cpm_pkg::chan_rec_t wr_data
);
    import cpm_pkg::*;

    chan_rec_t                mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]  vld_reg;
    chan_rec_t                rd_data_reg;
    logic                     rd_vld_reg;
    logic                     byp_reg;
    chan_rec_t                byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            byp_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
            // write lands at the same edge as the read: take the new record
            byp_reg    <= wr_en && (wr_addr == rd_addr);
        end
    end

    // an entry never written reads as the reset value (all zero)
    assign rd_data = byp_reg ? byp_data_reg : (rd_vld_reg ? rd_data_reg : '0);

endmodule

[hdl/cpm_scale.sv]
// Scaling stage: period times us_per_count, saturated to 32 bits.
module cpm_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  cpm_pkg::scale_req_t req,
    input  logic [15:0]        us_per_count,
    output logic               busy,
    output logic               push,
    output cpm_pkg::out_item_t push_data
);
    import cpm_pkg::*;

    logic                          s2_valid_reg;
    scale_req_t                    s2_req_reg;
    logic [STAMP_W+CFG_DATA_W-1:0] prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_req_reg <= req;
    end

    assign prod = s2_req_reg.period * us_per_count;

    always_comb
    begin
        push_data.status        = s2_req_reg.status;
        push_data.period_counts = s2_req_reg.period;
        if (|prod[STAMP_W+CFG_DATA_W-1:STAMP_W])
        begin
            push_data.period_us = '1;
        end
        else
        begin
            push_data.period_us = prod[STAMP_W-1:0];
        end
    end

    assign push = s2_valid_reg;
    assign busy = s2_valid_reg;

endmodule

[hdl/cpm_out_fifo.sv]
// Result queue between the pipeline and the response channel.
module cpm_out_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  cpm_pkg::out_item_t              push_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output cpm_pkg::out_item_t              rsp_data,
    output logic [cpm_pkg::FIFO_CNT_W-1:0]  count
);
    import cpm_pkg::*;

    out_item_t               buf_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign rsp_valid = (count_reg != '0);
    assign pop       = rsp_valid && !rsp_stall;
    assign rsp_data  = buf_mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

[hdl/capture_period_meter.sv]
// Top level of the multi-channel input-capture period meter.
//
// Usage:
//   req channel (req_valid/req_stall/req_data): one transaction per event:
//   capture (timestamp a channel edge), overflow tick, or period read.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): one transaction per read,
//   carrying status, the period in counts and the period in microseconds.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; write only while no transaction is in flight.
// Throughput: one request per cycle while req_stall is low. Channel state
// sits in a small memory with a registered read; a capture writes back in
// the following cycle and a same-channel request right behind it takes the
// written record by bypass. A read's response passes the memory read, the
// scaling multiply and the result queue in that order.
// Stall: results wait in a 4-entry queue; req_stall rises only once queued
// plus in-flight reads would fill it, so requests keep flowing while a
// response waits.
// Reset: overflow count and all channel records read as zero, registers
// take their defaults; no clearing pass, the block is ready at once.
module capture_period_meter #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  cpm_pkg::in_item_t                 req_data,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output cpm_pkg::out_item_t                rsp_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cpm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cpm_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration
    logic [CNT_W-1:0]   counter_top_reg;
    logic [CNT_W-1:0]   glitch_min_reg;
    logic [TMO_W-1:0]   timeout_ticks_reg;
    logic [CNT_W-1:0]   us_per_count_reg;

    logic [STAMP_W-1:0] ovf_reg;
    logic [STAMP_W-1:0] ovf_next;

    // stage 1
    logic               s1_cap_reg;
    logic               s1_rd_reg;
    logic               s1_ch_ok_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [CNT_W-1:0]   s1_cnt_reg;
    logic [STAMP_W-1:0] s1_ovf_reg;
    logic [STAMP_W-1:0] s1_prod_reg;

    logic               req_fire;
    logic               ch_ok;
    logic [AW-1:0]      rd_addr;
    chan_rec_t          rec;
    chan_rec_t          wr_rec;
    logic               wr_en;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] delta;
    logic [STAMP_W-1:0] since;
    scale_req_t         sreq;
    logic               s2_busy;
    logic               push;
    out_item_t          push_data;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [FIFO_CNT_W:0]   committed;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_top_reg   <= 16'hFFFF;
            glitch_min_reg    <= 16'd10;
            timeout_ticks_reg <= 8'd2;
            us_per_count_reg  <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COUNTER_TOP:   counter_top_reg   <= cfg_data;
                CFG_GLITCH_MIN:    glitch_min_reg    <= cfg_data;
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TMO_W-1:0];
                CFG_US_PER_COUNT:  us_per_count_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // queued results plus reads still in the pipe must leave room for one more
    assign committed = {1'b0, q_count} + (FIFO_CNT_W+1)'(s1_rd_reg)
                     + (FIFO_CNT_W+1)'(s2_busy);
    assign req_stall = committed >= (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign req_fire  = req_valid && !req_stall;

    assign ch_ok   = {1'b0, req_data.channel} < (CH_W+1)'(NUM_CHANNELS);
    assign rd_addr = req_data.channel[AW-1:0];

    assign ovf_next = (req_fire && req_data.op == OP_TICK) ? ovf_reg + 1'b1 : ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg      <= '0;
            s1_cap_reg   <= 1'b0;
            s1_rd_reg    <= 1'b0;
        end
        else
        begin
            ovf_reg    <= ovf_next;
            s1_cap_reg <= req_fire && req_data.op == OP_CAPTURE && ch_ok;
            s1_rd_reg  <= req_fire && req_data.op == OP_READ;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_ok_reg <= ch_ok;
        s1_addr_reg  <= rd_addr;
        s1_cnt_reg   <= req_data.capture_count;
        s1_ovf_reg   <= ovf_reg;
        // low 32 bits of overflow_count * (counter_top + 1)
        s1_prod_reg  <= STAMP_W'(ovf_reg * ({1'b0, counter_top_reg} + 17'd1));
    end

    cpm_chan_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AW           (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rec),
        .wr_en   (wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_rec)
    );

    // capture update
    assign stamp = s1_prod_reg + {{(STAMP_W-CNT_W){1'b0}}, s1_cnt_reg};
    assign delta = stamp - rec.acc_stamp;
    assign wr_en = s1_cap_reg;

    always_comb
    begin
        wr_rec.last_tick = s1_ovf_reg;
        if (delta >= {{(STAMP_W-CNT_W){1'b0}}, glitch_min_reg})
        begin
            wr_rec.acc_stamp = stamp;
            wr_rec.period    = delta;
        end
        else
        begin
            wr_rec.acc_stamp = rec.acc_stamp;
            wr_rec.period    = rec.period;
        end
    end

    // read: timeout check and bad channel
    assign since = s1_ovf_reg - rec.last_tick;

    always_comb
    begin
        sreq.status = STATUS_OK;
        sreq.period = '0;
        if (!s1_ch_ok_reg)
        begin
            sreq.status = STATUS_BAD_CHAN;
        end
        else if (since <= {{(STAMP_W-TMO_W){1'b0}}, timeout_ticks_reg})
        begin
            sreq.period = rec.period;
        end
    end

    cpm_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s1_rd_reg),
        .req          (sreq),
        .us_per_count (us_per_count_reg),
        .busy         (s2_busy),
        .push         (push),
        .push_data    (push_data)
    );

    cpm_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .count     (q_count)
    );

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        committed <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("more reads in flight than queue space");

    a_ovf_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg != $past(ovf_reg) |-> $past(req_fire && req_data.op == OP_TICK))
        else $error("overflow count moved without a tick");

    a_bad_chan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_data.status == STATUS_BAD_CHAN
            |-> push_data.period_counts == '0 && push_data.period_us == '0)
        else $error("bad channel read returned nonzero period");

endmodule
